// ===== hdl/pam_pkg.sv =====
// ----------------------------------------------------------------------------
// pam_pkg: shared definitions for the proximity attach matcher
// Opcodes, register indexes, stream field layout and storage word types.
// ----------------------------------------------------------------------------
package pam_pkg;

  // Item kinds carried in s_tuser.
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_PROBE = 2'd1;
  localparam logic [1:0] OP_SET   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_PROBE_RADIUS   = 2'd0;
  localparam logic [1:0] REG_TARGET_RADIUS  = 2'd1;
  localparam logic [1:0] REG_TARGETS_IN_USE = 2'd2;

  localparam int COORD_W = 16;
  localparam int COUNT_W = 16;
  localparam int INDEX_W = 10;
  localparam int HIT_W   = 6;
  localparam int TIU_W   = 7;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 40;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TIU_W-1:0]   TIU_RESET = 7'd64;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } pam_state_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } pam_pos_t;

  typedef struct packed {
    logic               live;
    logic [COUNT_W-1:0] tally;
  } pam_stat_t;

endpackage

// ===== hdl/proximity_attach_matcher_top.sv =====
// ----------------------------------------------------------------------------
// proximity_attach_matcher_top: probe-to-target proximity attach matcher
// Keeps a table of target points in block memory and attaches active probes
// to the first live target that lies within half the summed radii.
// ----------------------------------------------------------------------------
// The block takes one word at a time on the slave stream. A load word, a set
// word, a word with the unused opcode or an inactive probe goes from the idle
// state straight to the done state. An active probe walks the target table
// one entry per cycle through a read/compare pipeline (memory read, absolute
// differences, squaring, compare) until it attaches to a live target or has
// read all N entries, where N is the scan length min(targets_in_use,
// MAX_TARGETS). An item in the done state waits there for the output register
// to empty. After reset a clearing pass over all MAX_TARGETS entries zeroes
// the live flags and tallies; no word is accepted during that pass, while
// configuration writes are taken at any time. A finished result sits in the
// master-side output register, and the next slave word is accepted while it
// waits to be taken.
// ----------------------------------------------------------------------------
module proximity_attach_matcher_top #(
  parameter int MAX_TARGETS = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // Slave stream. s_tdata fields, lowest bit up: item_index[9:0],
  // x_coord[25:10], y_coord[41:26], active_in[42], start_value[58:43],
  // zero fill[63:59].
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [pam_pkg::IN_DATA_W-1:0] s_tdata,
  // s_tuser fields: opcode[1:0].
  input  logic [1:0]  s_tuser,
  // Master stream. m_tdata fields, lowest bit up: echo_index[9:0],
  // active_out[10], matched[11], hit_target[17:12], first_attach[18],
  // total_out[34:19], zero fill[39:35].
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [pam_pkg::OUT_DATA_W-1:0] m_tdata
);

  localparam int IDX_W = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int CNT_W = $clog2(MAX_TARGETS + 1);
  localparam int LEN_W = (CNT_W > pam_pkg::TIU_W) ? CNT_W : pam_pkg::TIU_W;

  // Unpacked input fields.
  logic [1:0]                    in_op;
  logic [pam_pkg::INDEX_W-1:0]   in_idx;
  logic [pam_pkg::COORD_W-1:0]   in_x;
  logic [pam_pkg::COORD_W-1:0]   in_y;
  logic                          in_act;
  logic [pam_pkg::COUNT_W-1:0]   in_sval;

  assign in_op   = s_tuser;
  assign in_idx  = s_tdata[9:0];
  assign in_x    = s_tdata[25:10];
  assign in_y    = s_tdata[41:26];
  assign in_act  = s_tdata[42];
  assign in_sval = s_tdata[58:43];

  // Configuration registers.
  logic [15:0]               probe_radius;
  logic [15:0]               target_radius;
  logic [pam_pkg::TIU_W-1:0] targets_in_use;
  logic [33:0]               radius_sq;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_radius   <= '0;
      target_radius  <= '0;
      targets_in_use <= pam_pkg::TIU_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pam_pkg::REG_PROBE_RADIUS:   probe_radius   <= cfg_data;
        pam_pkg::REG_TARGET_RADIUS:  target_radius  <= cfg_data;
        pam_pkg::REG_TARGETS_IN_USE: targets_in_use <= cfg_data[pam_pkg::TIU_W-1:0];
        default: ;
      endcase
    end
  end

  // The squared radius sum only changes with configuration, so it is kept
  // registered and ready well before any scan compares against it.
  logic [16:0] radius_sum;
  assign radius_sum = {1'b0, probe_radius} + {1'b0, target_radius};

  always_ff @(posedge clk) begin
    radius_sq <= 34'(radius_sum) * 34'(radius_sum);
  end

  // Control state.
  pam_pkg::pam_state_t state, state_next;
  logic [CNT_W-1:0]    clr_cnt;
  logic [CNT_W-1:0]    rd_cnt;
  logic [CNT_W-1:0]    scan_len;
  logic [CNT_W-1:0]    scan_len_in;
  logic [LEN_W-1:0]    tiu_ext;
  logic [15:0]         running_total;

  // Current item.
  logic [pam_pkg::INDEX_W-1:0] cur_idx;
  logic [pam_pkg::COORD_W-1:0] cur_x;
  logic [pam_pkg::COORD_W-1:0] cur_y;

  // Result of the current item.
  logic                      res_active;
  logic                      res_matched;
  logic [pam_pkg::HIT_W-1:0] res_hit;
  logic                      res_first;

  // Handshakes and strobes.
  logic s_acc;
  logic out_free;
  logic clr_last;
  logic issue;
  logic scan_end;
  logic load_ok;
  logic hit;

  // Memory ports.
  logic              pos_we;
  logic [IDX_W-1:0]  pos_wa;
  pam_pkg::pam_pos_t pos_wd;
  pam_pkg::pam_pos_t pos_q;
  logic               stat_we;
  logic [IDX_W-1:0]   stat_wa;
  pam_pkg::pam_stat_t stat_wd;
  pam_pkg::pam_stat_t stat_q;
  logic [IDX_W-1:0]   rd_addr;

  // Scan pipeline.
  logic                        v1, v2, v3;
  logic [IDX_W-1:0]            idx1, idx2, idx3;
  logic [pam_pkg::COORD_W-1:0] dx, dy;
  logic [31:0]                 dx_sq, dy_sq;
  logic                        live2, live3;
  logic [pam_pkg::COUNT_W-1:0] tally2, tally3;
  logic [32:0]                 dist_sq;
  logic                        near;
  logic [pam_pkg::COUNT_W-1:0] tally_new;
  logic                        first_hit;

  assign s_acc    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign clr_last = (clr_cnt == CNT_W'(MAX_TARGETS - 1));
  assign scan_end = (rd_cnt == scan_len) && !v1 && !v2 && !v3;
  assign load_ok  = ({1'b0, in_idx} < 11'(MAX_TARGETS));
  assign rd_addr  = rd_cnt[IDX_W-1:0];

  // Scans never run past the table, whatever targets_in_use holds.
  always_comb begin
    tiu_ext = LEN_W'(targets_in_use);
    if (tiu_ext > LEN_W'(MAX_TARGETS)) begin
      scan_len_in = CNT_W'(MAX_TARGETS);
    end else begin
      scan_len_in = CNT_W'(tiu_ext);
    end
  end

  // Distance test: 4 * (dx^2 + dy^2) < (rp + rt)^2, exact in integers.
  assign dist_sq = {1'b0, dx_sq} + {1'b0, dy_sq};
  assign near    = ({dist_sq, 2'b00} < {1'b0, radius_sq});
  assign hit     = v3 && live3 && near;

  // A saturated tally stays put and never reports a first attachment.
  assign first_hit = (tally3 == '0);
  assign tally_new = (tally3 == pam_pkg::COUNT_MAX) ? tally3 : tally3 + 1'b1;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      pam_pkg::ST_CLEAR: begin
        if (clr_last) state_next = pam_pkg::ST_IDLE;
      end
      pam_pkg::ST_IDLE: begin
        if (s_acc) begin
          if (in_op == pam_pkg::OP_PROBE && in_act) state_next = pam_pkg::ST_SCAN;
          else state_next = pam_pkg::ST_DONE;
        end
      end
      pam_pkg::ST_SCAN: begin
        if (hit || scan_end) state_next = pam_pkg::ST_DONE;
      end
      pam_pkg::ST_DONE: begin
        if (out_free) state_next = pam_pkg::ST_IDLE;
      end
      default: state_next = pam_pkg::ST_CLEAR;
    endcase
  end

  // State outputs: handshake, read issue and memory write selection.
  always_comb begin
    s_tready = 1'b0;
    issue    = 1'b0;
    pos_we   = 1'b0;
    pos_wa   = in_idx[IDX_W-1:0];
    pos_wd   = '{x: in_x, y: in_y};
    stat_we  = 1'b0;
    stat_wa  = in_idx[IDX_W-1:0];
    stat_wd  = '{live: in_act, tally: in_sval};
    unique case (state)
      pam_pkg::ST_CLEAR: begin
        stat_we = 1'b1;
        stat_wa = clr_cnt[IDX_W-1:0];
        stat_wd = '0;
      end
      pam_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_acc && in_op == pam_pkg::OP_LOAD && load_ok) begin
          pos_we  = 1'b1;
          stat_we = 1'b1;
        end
      end
      pam_pkg::ST_SCAN: begin
        issue = (rd_cnt != scan_len) && !hit;
        if (hit) begin
          stat_we = 1'b1;
          stat_wa = idx3;
          stat_wd = '{live: 1'b1, tally: tally_new};
        end
      end
      pam_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= pam_pkg::ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == pam_pkg::ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Target position and status memories, one read and one write port each.
  pam_pkg::pam_pos_t  pos_mem  [MAX_TARGETS];
  pam_pkg::pam_stat_t stat_mem [MAX_TARGETS];

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    pos_q <= pos_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (stat_we) stat_mem[stat_wa] <= stat_wd;
    stat_q <= stat_mem[rd_addr];
  end

  // Pipeline valids; a hit drops everything still in flight behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1 && !hit;
      v3 <= v2 && !hit;
    end
  end

  always_ff @(posedge clk) begin
    idx1   <= rd_addr;
    idx2   <= idx1;
    idx3   <= idx2;
    dx     <= (cur_x >= pos_q.x) ? cur_x - pos_q.x : pos_q.x - cur_x;
    dy     <= (cur_y >= pos_q.y) ? cur_y - pos_q.y : pos_q.y - cur_y;
    live2  <= stat_q.live;
    tally2 <= stat_q.tally;
    dx_sq  <= 32'(dx) * 32'(dx);
    dy_sq  <= 32'(dy) * 32'(dy);
    live3  <= live2;
    tally3 <= tally2;
  end

  // Item capture, scan counter, running total and result fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt        <= '0;
      scan_len      <= '0;
      running_total <= '0;
    end else begin
      if (s_acc) begin
        rd_cnt   <= '0;
        scan_len <= scan_len_in;
        if (in_op == pam_pkg::OP_SET) running_total <= in_sval;
      end else if (issue) begin
        rd_cnt <= rd_cnt + 1'b1;
      end
      if (hit && first_hit && running_total != pam_pkg::COUNT_MAX) begin
        running_total <= running_total + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      cur_idx     <= in_idx;
      cur_x       <= in_x;
      cur_y       <= in_y;
      res_active  <= (in_op == pam_pkg::OP_PROBE) && in_act;
      res_matched <= 1'b0;
      res_hit     <= '0;
      res_first   <= 1'b0;
    end else if (hit) begin
      res_active  <= 1'b0;
      res_matched <= 1'b1;
      res_hit     <= pam_pkg::HIT_W'(idx3);
      res_first   <= first_hit;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == pam_pkg::ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == pam_pkg::ST_DONE && out_free) begin
      m_tdata <= {5'b0, running_total, res_first, res_hit, res_matched, res_active, cur_idx};
    end
  end

  // A probe that attached is never reported as still active.
  a_match_inactive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[11] |-> !m_tdata[10])
    else $error("matched result still active");

  // A first attachment only comes with a match.
  a_first_needs_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[18] |-> m_tdata[11])
    else $error("first attach without match");

  // A nonzero target index only comes with a match.
  a_hit_needs_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[17:12] != '0) |-> m_tdata[11])
    else $error("hit index without match");

  // One item at a time: after an acceptance the block stops taking words.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_acc |=> !s_tready)
    else $error("second word accepted while busy");

  // The scan never reads past its length.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == pam_pkg::ST_SCAN |-> rd_cnt <= scan_len)
    else $error("scan counter past scan length");

endmodule
